/* rtl/keyvalue_text_tokenizer_assert.svh */
// Assertion helpers for the key/value tokenizer. Each check is sampled on the
// rising clock edge and is switched off while reset is high.
`ifndef KEYVALUE_TEXT_TOKENIZER_ASSERT_SVH
`define KEYVALUE_TEXT_TOKENIZER_ASSERT_SVH

// Same-cycle implication.
`define TKZ_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define TKZ_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/tkz_pkg.sv */
package tkz_pkg;

   localparam int unsigned TKZ_CHAR_W  = 21;
   localparam int unsigned TKZ_DEPTH_W = 16;
   localparam int unsigned TKZ_KIND_W  = 3;
   localparam int unsigned TKZ_REQ_W   = 24;
   localparam int unsigned TKZ_RSP_W   = 40;

   // A pending CR is fed as its own character first: at most three loop
   // passes for it, four for the character itself.
   localparam int unsigned TKZ_CR_PASSES   = 3;
   localparam int unsigned TKZ_CHAR_PASSES = 4;

   localparam logic [31:0] TKZ_MAX_DEPTH = 32'd65535;
   localparam logic [TKZ_DEPTH_W-1:0] TKZ_DEPTH_LIMIT =
      (TKZ_MAX_DEPTH < 32'd65535) ? TKZ_MAX_DEPTH[TKZ_DEPTH_W-1:0] : 16'hFFFF;

   typedef logic [TKZ_CHAR_W-1:0]  tkz_char_type;
   typedef logic [TKZ_DEPTH_W-1:0] tkz_depth_type;
   typedef logic [TKZ_KIND_W-1:0]  tkz_kind_type;

   localparam tkz_kind_type TKZ_K_KEY    = 3'd0;
   localparam tkz_kind_type TKZ_K_VAL    = 3'd1;
   localparam tkz_kind_type TKZ_K_SSTART = 3'd2;
   localparam tkz_kind_type TKZ_K_PAIR   = 3'd3;
   localparam tkz_kind_type TKZ_K_SEND   = 3'd4;
   localparam tkz_kind_type TKZ_K_END    = 3'd5;
   localparam tkz_kind_type TKZ_K_ERR    = 3'd6;

   localparam tkz_char_type TKZ_C_NUL    = 21'd0;
   localparam tkz_char_type TKZ_C_BEL    = 21'd7;
   localparam tkz_char_type TKZ_C_BS     = 21'd8;
   localparam tkz_char_type TKZ_C_TAB    = 21'd9;
   localparam tkz_char_type TKZ_C_LF     = 21'd10;
   localparam tkz_char_type TKZ_C_VT     = 21'd11;
   localparam tkz_char_type TKZ_C_FF     = 21'd12;
   localparam tkz_char_type TKZ_C_CR     = 21'd13;
   localparam tkz_char_type TKZ_C_SPACE  = 21'd32;
   localparam tkz_char_type TKZ_C_QUOTE  = 21'd34;
   localparam tkz_char_type TKZ_C_APOS   = 21'd39;
   localparam tkz_char_type TKZ_C_SLASH  = 21'd47;
   localparam tkz_char_type TKZ_C_QMARK  = 21'd63;
   localparam tkz_char_type TKZ_C_BSLASH = 21'd92;
   localparam tkz_char_type TKZ_C_LC_A   = 21'd97;
   localparam tkz_char_type TKZ_C_LC_B   = 21'd98;
   localparam tkz_char_type TKZ_C_LC_F   = 21'd102;
   localparam tkz_char_type TKZ_C_LC_N   = 21'd110;
   localparam tkz_char_type TKZ_C_LC_R   = 21'd114;
   localparam tkz_char_type TKZ_C_LC_T   = 21'd116;
   localparam tkz_char_type TKZ_C_LC_V   = 21'd118;
   localparam tkz_char_type TKZ_C_LBRACE = 21'd123;
   localparam tkz_char_type TKZ_C_RBRACE = 21'd125;

   typedef enum logic [3:0] {
      TKZ_SKIP_KEY    = 4'd0,
      TKZ_SLASH_KEY   = 4'd1,
      TKZ_COMMENT_KEY = 4'd2,
      TKZ_KEY_UNQ     = 4'd3,
      TKZ_KEY_Q       = 4'd4,
      TKZ_SKIP_VAL    = 4'd5,
      TKZ_SLASH_VAL   = 4'd6,
      TKZ_COMMENT_VAL = 4'd7,
      TKZ_VAL_UNQ     = 4'd8,
      TKZ_VAL_Q       = 4'd9
   } tkz_phase_type;

   typedef struct packed {
      tkz_phase_type phase;
      tkz_depth_type depth;
      logic          pbs;
      logic          failed;
   } tkz_state_type;

   localparam tkz_state_type TKZ_STATE_RESET =
      '{phase: TKZ_SKIP_KEY, depth: 16'd0, pbs: 1'b0, failed: 1'b0};

   typedef struct packed {
      tkz_depth_type depth;
      tkz_char_type  ch;
      tkz_kind_type  kind;
   } tkz_res_type;

   // One pass of the parse loop: up to two results and a flag to run again.
   typedef struct packed {
      tkz_state_type    s;
      logic             cont;
      logic [1:0]       n;
      tkz_res_type [1:0] r;
   } tkz_iter_type;

   // Results of one request, packed from entry 0.
   typedef struct packed {
      logic [2:0]        cnt;
      tkz_res_type [3:0] res;
   } tkz_grp_type;

   function automatic logic tkz_is_space(tkz_char_type c);
      return (c == TKZ_C_SPACE) || ((c >= TKZ_C_TAB) && (c <= TKZ_C_CR));
   endfunction

   function automatic tkz_char_type tkz_escape(tkz_char_type c);
      tkz_char_type m;
      case (c)
         TKZ_C_LC_N:   m = TKZ_C_LF;
         TKZ_C_LC_T:   m = TKZ_C_TAB;
         TKZ_C_LC_V:   m = TKZ_C_VT;
         TKZ_C_LC_B:   m = TKZ_C_BS;
         TKZ_C_LC_R:   m = TKZ_C_CR;
         TKZ_C_LC_F:   m = TKZ_C_FF;
         TKZ_C_LC_A:   m = TKZ_C_BEL;
         TKZ_C_BSLASH: m = TKZ_C_BSLASH;
         TKZ_C_QMARK:  m = TKZ_C_QMARK;
         TKZ_C_APOS:   m = TKZ_C_APOS;
         TKZ_C_QUOTE:  m = TKZ_C_QUOTE;
         default:      m = TKZ_C_NUL;
      endcase
      return m;
   endfunction

   function automatic tkz_res_type tkz_res(tkz_kind_type k, tkz_char_type c,
                                           tkz_depth_type d);
      tkz_res_type r;
      r.kind  = k;
      r.ch    = c;
      r.depth = d;
      return r;
   endfunction

   function automatic tkz_iter_type tkz_quoted(tkz_state_type s, tkz_char_type c,
                                               logic esc, tkz_kind_type k);
      tkz_iter_type o;
      tkz_char_type m;
      logic         hit;
      o      = '0;
      o.s    = s;
      hit    = 1'b0;
      m      = tkz_escape(c);
      if (s.pbs) begin
         o.s.pbs = 1'b0;
         if (m != TKZ_C_NUL) begin
            o.r[0] = tkz_res(k, m, s.depth);
            hit    = 1'b1;
         end else begin
            o.r[0] = tkz_res(k, TKZ_C_BSLASH, s.depth);
         end
         o.n = 2'd1;
      end
      if (!hit) begin
         if (c == TKZ_C_NUL) begin
            // unclosed quote at end of stream
            o.r[o.n[0]] = tkz_res(TKZ_K_ERR, TKZ_C_NUL, s.depth);
            o.n         = o.n + 2'd1;
            o.s         = TKZ_STATE_RESET;
         end else if (c == TKZ_C_QUOTE) begin
            if (k == TKZ_K_KEY) begin
               o.s.phase = TKZ_SKIP_VAL;
            end else begin
               o.r[o.n[0]] = tkz_res(TKZ_K_PAIR, TKZ_C_NUL, s.depth);
               o.n         = o.n + 2'd1;
               o.s.phase   = TKZ_SKIP_KEY;
            end
         end else if ((c == TKZ_C_BSLASH) && esc) begin
            o.s.pbs = 1'b1;
         end else begin
            o.r[o.n[0]] = tkz_res(k, c, s.depth);
            o.n         = o.n + 2'd1;
         end
      end
      return o;
   endfunction

   function automatic tkz_iter_type tkz_iter(tkz_state_type s, tkz_char_type c, logic esc);
      tkz_iter_type o;
      logic         spc;
      logic         ends;
      logic         eol;
      o    = '0;
      o.s  = s;
      spc  = tkz_is_space(c);
      ends = (c == TKZ_C_NUL) || spc || (c == TKZ_C_QUOTE) ||
             (c == TKZ_C_LBRACE) || (c == TKZ_C_RBRACE);
      eol  = (c == TKZ_C_CR) || (c == TKZ_C_LF);
      if (s.failed) begin
         // drop everything up to the end marker
         if (c == TKZ_C_NUL) o.s = TKZ_STATE_RESET;
      end else begin
         unique case (s.phase)
            TKZ_SLASH_KEY: begin
               if (c == TKZ_C_SLASH) begin
                  o.s.phase = TKZ_COMMENT_KEY;
               end else begin
                  o.r[0]    = tkz_res(TKZ_K_KEY, TKZ_C_SLASH, s.depth);
                  o.n       = 2'd1;
                  o.s.phase = TKZ_KEY_UNQ;
                  o.cont    = 1'b1;
               end
            end
            TKZ_COMMENT_KEY: begin
               if (c == TKZ_C_NUL) begin
                  o.s.phase = TKZ_SKIP_KEY;
                  o.cont    = 1'b1;
               end else if (eol) begin
                  o.s.phase = TKZ_SKIP_KEY;
               end
            end
            TKZ_KEY_UNQ: begin
               if (ends) begin
                  o.s.phase = TKZ_SKIP_VAL;
                  o.cont    = 1'b1;
               end else begin
                  o.r[0] = tkz_res(TKZ_K_KEY, c, s.depth);
                  o.n    = 2'd1;
               end
            end
            TKZ_KEY_Q: o = tkz_quoted(s, c, esc, TKZ_K_KEY);
            TKZ_SKIP_VAL: begin
               if (c == TKZ_C_NUL) begin
                  o.r[0] = tkz_res(TKZ_K_END, TKZ_C_NUL, s.depth);
                  o.n    = 2'd1;
                  o.s    = TKZ_STATE_RESET;
               end else if (spc) begin
                  o.s = s;
               end else if (c == TKZ_C_SLASH) begin
                  o.s.phase = TKZ_SLASH_VAL;
               end else if (c == TKZ_C_LBRACE) begin
                  if (s.depth >= TKZ_DEPTH_LIMIT) begin
                     o.r[0]   = tkz_res(TKZ_K_ERR, TKZ_C_NUL, s.depth);
                     o.n      = 2'd1;
                     o.s.failed = 1'b1;
                  end else begin
                     o.s.depth = s.depth + 16'd1;
                     o.r[0]    = tkz_res(TKZ_K_SSTART, TKZ_C_NUL, o.s.depth);
                     o.n       = 2'd1;
                     o.s.phase = TKZ_SKIP_KEY;
                  end
               end else if (c == TKZ_C_QUOTE) begin
                  o.s.phase = TKZ_VAL_Q;
               end else if (c == TKZ_C_RBRACE) begin
                  // empty value: close the pair, then treat the brace again
                  o.r[0]    = tkz_res(TKZ_K_PAIR, TKZ_C_NUL, s.depth);
                  o.n       = 2'd1;
                  o.s.phase = TKZ_SKIP_KEY;
                  o.cont    = 1'b1;
               end else begin
                  o.r[0]    = tkz_res(TKZ_K_VAL, c, s.depth);
                  o.n       = 2'd1;
                  o.s.phase = TKZ_VAL_UNQ;
               end
            end
            TKZ_SLASH_VAL: begin
               if (c == TKZ_C_SLASH) begin
                  o.s.phase = TKZ_COMMENT_VAL;
               end else begin
                  o.r[0]    = tkz_res(TKZ_K_VAL, TKZ_C_SLASH, s.depth);
                  o.n       = 2'd1;
                  o.s.phase = TKZ_VAL_UNQ;
                  o.cont    = 1'b1;
               end
            end
            TKZ_COMMENT_VAL: begin
               if (c == TKZ_C_NUL) begin
                  o.s.phase = TKZ_SKIP_VAL;
                  o.cont    = 1'b1;
               end else if (eol) begin
                  o.s.phase = TKZ_SKIP_VAL;
               end
            end
            TKZ_VAL_UNQ: begin
               if (ends) begin
                  o.r[0]    = tkz_res(TKZ_K_PAIR, TKZ_C_NUL, s.depth);
                  o.n       = 2'd1;
                  o.s.phase = TKZ_SKIP_KEY;
                  o.cont    = 1'b1;
               end else begin
                  o.r[0] = tkz_res(TKZ_K_VAL, c, s.depth);
                  o.n    = 2'd1;
               end
            end
            TKZ_VAL_Q: o = tkz_quoted(s, c, esc, TKZ_K_VAL);
            default: begin
               o.s.phase = TKZ_SKIP_KEY;
               if (c == TKZ_C_NUL) begin
                  o.r[0] = tkz_res(TKZ_K_END, TKZ_C_NUL, s.depth);
                  o.n    = 2'd1;
                  o.s    = TKZ_STATE_RESET;
               end else if (spc) begin
                  o.cont = 1'b0;
               end else if (c == TKZ_C_SLASH) begin
                  o.s.phase = TKZ_SLASH_KEY;
               end else if (c == TKZ_C_LBRACE) begin
                  o.r[0]     = tkz_res(TKZ_K_ERR, TKZ_C_NUL, s.depth);
                  o.n        = 2'd1;
                  o.s.failed = 1'b1;
               end else if (c == TKZ_C_RBRACE) begin
                  if (s.depth == 16'd0) begin
                     o.r[0]     = tkz_res(TKZ_K_ERR, TKZ_C_NUL, s.depth);
                     o.n        = 2'd1;
                     o.s.failed = 1'b1;
                  end else begin
                     o.s.depth = s.depth - 16'd1;
                     o.r[0]    = tkz_res(TKZ_K_SEND, TKZ_C_NUL, o.s.depth);
                     o.n       = 2'd1;
                  end
               end else if (c == TKZ_C_QUOTE) begin
                  o.s.phase = TKZ_KEY_Q;
               end else begin
                  o.r[0]    = tkz_res(TKZ_K_KEY, c, s.depth);
                  o.n       = 2'd1;
                  o.s.phase = TKZ_KEY_UNQ;
               end
            end
         endcase
      end
      return o;
   endfunction

   // Append the results of one pass, dropping anything past the fourth.
   function automatic tkz_grp_type tkz_collect(tkz_grp_type g, tkz_iter_type it);
      if ((it.n != 2'd0) && (g.cnt < 3'd4)) begin
         g.res[g.cnt[1:0]] = it.r[0];
         g.cnt             = g.cnt + 3'd1;
      end
      if ((it.n == 2'd2) && (g.cnt < 3'd4)) begin
         g.res[g.cnt[1:0]] = it.r[1];
         g.cnt             = g.cnt + 3'd1;
      end
      return g;
   endfunction

endpackage

/* rtl/tkz_core.sv */
module tkz_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic                          csr_wr_data,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [tkz_pkg::TKZ_REQ_W-1:0] req_tdata,
   input  logic                          push_ready,
   output logic                          push_valid,
   output tkz_pkg::tkz_grp_type          push_grp
);
   import tkz_pkg::*;

   logic          in_vld_ff;
   logic          in_vld_in;
   tkz_char_type  char_ff;
   tkz_char_type  char_in;
   tkz_state_type state_ff;
   tkz_state_type state_in;
   logic          pcr_ff;
   logic          pcr_in;
   logic          esc_ff;
   logic          esc_in;
   logic          advance;
   tkz_state_type state_calc;
   tkz_grp_type   grp_calc;

   assign advance    = in_vld_ff && push_ready;
   assign req_tready = !in_vld_ff || push_ready;
   assign push_valid = advance && (grp_calc.cnt != 3'd0);
   assign push_grp   = grp_calc;

   // Fold a held CR into the stream, then run the parse loop on the character.
   always_comb begin
      tkz_state_type st;
      tkz_grp_type   g;
      tkz_iter_type  it;
      logic          run;
      st  = state_ff;
      g   = '0;
      it  = '0;
      run = pcr_ff && (char_ff != TKZ_C_LF);
      for (int i = 0; i < TKZ_CR_PASSES; i++) begin
         if (run) begin
            it  = tkz_iter(st, TKZ_C_CR, esc_ff);
            st  = it.s;
            g   = tkz_collect(g, it);
            run = it.cont;
         end
      end
      pcr_in = (char_ff == TKZ_C_CR) && !st.failed;
      run    = !pcr_in;
      for (int i = 0; i < TKZ_CHAR_PASSES; i++) begin
         if (run) begin
            it  = tkz_iter(st, char_ff, esc_ff);
            st  = it.s;
            g   = tkz_collect(g, it);
            run = it.cont;
         end
      end
      state_calc = st;
      grp_calc   = g;
   end

   always_comb begin
      in_vld_in = in_vld_ff;
      char_in   = char_ff;
      state_in  = state_ff;
      esc_in    = esc_ff;
      if (advance) begin
         in_vld_in = 1'b0;
         state_in  = state_calc;
      end
      if (req_tvalid && req_tready) begin
         in_vld_in = 1'b1;
         char_in   = req_tdata[TKZ_CHAR_W-1:0];
      end
      if (csr_wr_en) esc_in = csr_wr_data;
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
      if (reset) begin
         in_vld_ff <= 1'b0;
         state_ff  <= TKZ_STATE_RESET;
         pcr_ff    <= 1'b0;
         esc_ff    <= 1'b1;
      end else begin
         in_vld_ff <= in_vld_in;
         state_ff  <= state_in;
         esc_ff    <= esc_in;
         if (advance) pcr_ff <= pcr_in;
      end
   end

endmodule

/* rtl/tkz_out.sv */
module tkz_out (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push_valid,
   input  tkz_pkg::tkz_grp_type          push_grp,
   output logic                          push_ready,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [tkz_pkg::TKZ_RSP_W-1:0] rsp_tdata,
   output logic                          rsp_tlast
);
   import tkz_pkg::*;

   logic        grp_vld_ff;
   logic        grp_vld_in;
   logic [1:0]  idx_ff;
   logic [1:0]  idx_in;
   tkz_grp_type grp_ff;
   tkz_grp_type grp_in;
   logic [2:0]  cnt_m1;
   logic        last;
   logic        pop;
   tkz_res_type cur;

   assign cnt_m1     = grp_ff.cnt - 3'd1;
   assign last       = ({1'b0, idx_ff} == cnt_m1);
   assign pop        = grp_vld_ff && rsp_tready && last;
   assign push_ready = !grp_vld_ff || pop;
   assign cur        = grp_ff.res[idx_ff];

   assign rsp_tvalid = grp_vld_ff;
   assign rsp_tdata  = {cur.depth, cur.ch, cur.kind};
   assign rsp_tlast  = last;

   always_comb begin
      grp_vld_in = grp_vld_ff;
      idx_in     = idx_ff;
      grp_in     = grp_ff;
      if (push_valid && push_ready) begin
         grp_vld_in = 1'b1;
         idx_in     = 2'd0;
         grp_in     = push_grp;
      end else if (pop) begin
         grp_vld_in = 1'b0;
      end else if (grp_vld_ff && rsp_tready) begin
         // advance to the next result of this request
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      grp_ff <= grp_in;
      if (reset) begin
         grp_vld_ff <= 1'b0;
         idx_ff     <= 2'd0;
      end else begin
         grp_vld_ff <= grp_vld_in;
         idx_ff     <= idx_in;
      end
   end

endmodule

/* rtl/keyvalue_text_tokenizer.sv */
// Channel    Dir  Signals                                Contents
// req_       in   req_tvalid, req_tready, req_tdata      one code point per request
// rsp_       out  rsp_tvalid, rsp_tready, rsp_tdata,     one token event per transfer
//                 rsp_tlast
// csr_       in   csr_wr_en, csr_wr_data                 escape enable
//
// A request is parsed combinationally from the input register into a group buffer.
// A request yielding n events (0 to 4) holds the group buffer until they are taken;
// with at most one event each and rsp_tready high, it sustains one request per cycle.
// The input register takes the next request while the group buffer drains.
// Synchronous active-high reset; escapes enabled after reset, no clearing pass.
`include "keyvalue_text_tokenizer_assert.svh"

module keyvalue_text_tokenizer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic                          csr_wr_data,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // [20:0] character, [23:21] zero
   input  logic [tkz_pkg::TKZ_REQ_W-1:0] req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // [2:0] kind, [23:3] out_char, [39:24] depth
   output logic [tkz_pkg::TKZ_RSP_W-1:0] rsp_tdata,
   output logic                          rsp_tlast
);
   import tkz_pkg::*;

   logic          push_valid;
   logic          push_ready;
   tkz_grp_type   push_grp;
   tkz_kind_type  rsp_kind;
   tkz_char_type  rsp_char;
   tkz_depth_type rsp_depth;

   tkz_core u_core (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .push_ready  (push_ready),
      .push_valid  (push_valid),
      .push_grp    (push_grp)
   );

   tkz_out u_out (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_grp   (push_grp),
      .push_ready (push_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   assign rsp_kind  = rsp_tdata[TKZ_KIND_W-1:0];
   assign rsp_char  = rsp_tdata[TKZ_KIND_W+TKZ_CHAR_W-1:TKZ_KIND_W];
   assign rsp_depth = rsp_tdata[TKZ_RSP_W-1:TKZ_KIND_W+TKZ_CHAR_W];

   `TKZ_ASSERT_NOW(a_char_only_on_strings,
      rsp_tvalid && (rsp_kind != TKZ_K_KEY) && (rsp_kind != TKZ_K_VAL),
      rsp_char == TKZ_C_NUL, "non-string event carries a character")
   `TKZ_ASSERT_NOW(a_end_is_last,
      rsp_tvalid && ((rsp_kind == TKZ_K_END) || (rsp_kind == TKZ_K_ERR)),
      rsp_tlast, "end event is not the last of its request")
   `TKZ_ASSERT_NOW(a_section_depth,
      rsp_tvalid && (rsp_kind == TKZ_K_SSTART), rsp_depth != 16'd0,
      "section start at depth zero")
   `TKZ_ASSERT_NEXT(a_group_continues,
      rsp_tvalid && rsp_tready && !rsp_tlast, rsp_tvalid,
      "request results broken off before the last")

endmodule
